>>> hdl/btg_pkg.sv
// ----------------------------------------------------------------------------
// btg_pkg - shared types and constants of the beat tone generator
// Register codes, configuration and job records, and the quarter-wave sine ROM.
// ----------------------------------------------------------------------------
package btg_pkg;

  // beat length and sine table size
  localparam int SAMPLES_PER_NOTE = 48000;
  localparam int SINE_TABLE_BITS  = 10;
  localparam int QSIZE            = 1 << SINE_TABLE_BITS;
  localparam int TAB_AW           = SINE_TABLE_BITS + 1;

  localparam logic [15:0]       LAST_INDEX = 16'(SAMPLES_PER_NOTE - 1);
  localparam logic [TAB_AW-1:0] QSIZE_A    = TAB_AW'(QSIZE);

  // pi/2 in Q30
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  // configuration register indexes
  localparam logic [2:0] REG_RAMP_LENGTH       = 3'd0;
  localparam logic [2:0] REG_SINE_PEAK         = 3'd1;
  localparam logic [2:0] REG_SQUARE_PEAK       = 3'd2;
  localparam logic [2:0] REG_BEATS_PER_MEASURE = 3'd3;
  localparam logic [2:0] REG_ROOT_STEP         = 3'd4;

  // register reset values
  localparam logic [14:0] RST_RAMP_LENGTH       = 15'd24000;
  localparam logic [13:0] RST_SINE_PEAK         = 14'd2512;
  localparam logic [13:0] RST_SQUARE_PEAK       = 14'd316;
  localparam logic [6:0]  RST_BEATS_PER_MEASURE = 7'd8;
  localparam logic [31:0] RST_ROOT_STEP         = 32'd11698770;

  // configuration register file
  typedef struct packed {
    logic [14:0] ramp_length;
    logic [13:0] sine_peak;
    logic [13:0] square_peak;
    logic [6:0]  beats_per_measure;
    logic [31:0] root_step;
  } cfg_t;

  // one classified sample request, front to back
  typedef struct packed {
    logic        active;
    logic        accent;
    logic        last;
    logic [15:0] idx;
    logic [31:0] phase;
  } job_t;

  // queue status seen by both ends
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef logic [14:0] sin_tab_t [0:QSIZE];

  // next series term: previous term times x in Q30, over (2n)(2n+1), sign flipped
  function automatic longint taylor_term(input longint prev, input longint x, input int n);
    longint t;
    t = (prev * x) / 64'sd1073741824;
    case (n)
      1:       return -(t / 64'sd6);
      2:       return -(t / 64'sd20);
      3:       return -(t / 64'sd42);
      4:       return -(t / 64'sd72);
      5:       return -(t / 64'sd110);
      6:       return -(t / 64'sd156);
      default: return -(t / 64'sd210);
    endcase
  endfunction

  // Q15 quarter-wave sine: Q30 series to x^8, each term the last times x, rounded half up
  function automatic sin_tab_t build_sin_tab();
    sin_tab_t tab;
    longint   x;
    longint   term;
    longint   total;
    longint   v;
    int       k;
    int       n;
    for (k = 0; k <= QSIZE; k++) begin
      x     = (HALF_PI_Q30 * longint'(k)) >>> SINE_TABLE_BITS;
      term  = x;
      total = x;
      for (n = 1; n <= 7; n++) begin
        term  = taylor_term(term, x, n);
        total = total + term;
      end
      if (total < 0) total = 0;
      v = (total + 64'sd16384) / 64'sd32768;
      if (v > 64'sd32767) v = 64'sd32767;
      tab[k] = v[14:0];
    end
    return tab;
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin_tab();

endpackage

>>> hdl/btg_front.sv
// ----------------------------------------------------------------------------
// btg_front - tick intake and beat sequencing
// Takes tick requests, keeps beat count, phase and index, queues one job each.
// ----------------------------------------------------------------------------
module btg_front (
  input  logic              clk,
  input  logic              rst,
  input  btg_pkg::cfg_t     cfg,
  input  logic              tick_valid,
  output logic              tick_stall,
  input  logic              start_req,
  input  logic [31:0]       note_step,
  input  btg_pkg::qstat_t   qstat,
  output logic              push,
  output btg_pkg::job_t     job
);

  logic [31:0] phase_acc;
  logic [15:0] sample_index;
  logic [6:0]  beat_count;
  logic        note_active;
  logic        accent_beat;
  logic [31:0] current_step;

  logic [6:0]  bpm;
  logic        start_acc;
  logic        act;
  logic        acc;
  logic [31:0] step;
  logic [31:0] phs;
  logic [15:0] idx;
  logic        is_last;

  // accept whenever the queue has room
  assign tick_stall = qstat.full;
  assign push       = tick_valid && !qstat.full;

  // classify the tick: new beat or continuation
  always_comb begin
    bpm       = (cfg.beats_per_measure == 7'd0) ? 7'd1 : cfg.beats_per_measure;
    start_acc = beat_count >= bpm;
    if (start_req) begin
      act  = 1'b1;
      acc  = start_acc;
      step = start_acc ? cfg.root_step : note_step;
      phs  = 32'd0;
      idx  = 16'd0;
    end else begin
      act  = note_active;
      acc  = accent_beat;
      step = current_step;
      phs  = phase_acc;
      idx  = sample_index;
    end
    is_last = act && (idx >= btg_pkg::LAST_INDEX);
  end

  // job record
  always_comb begin
    job.active = act;
    job.accent = act && acc;
    job.last   = is_last;
    job.idx    = idx;
    job.phase  = phs;
  end

  // beat state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc    <= 32'd0;
      sample_index <= 16'd0;
      beat_count   <= 7'd1;
      note_active  <= 1'b0;
      accent_beat  <= 1'b0;
      current_step <= 32'd0;
    end else if (push) begin
      if (start_req) begin
        beat_count   <= start_acc ? 7'd1 : beat_count + 7'd1;
        accent_beat  <= start_acc;
        current_step <= step;
      end
      if (act) begin
        sample_index <= idx + 16'd1;
        phase_acc    <= phs + step;
        note_active  <= !is_last;
      end
    end
  end

endmodule

>>> hdl/btg_queue.sv
// ----------------------------------------------------------------------------
// btg_queue - two-entry job queue
// Decouples the front from the back so either side can stall on its own.
// ----------------------------------------------------------------------------
module btg_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  btg_pkg::job_t     wr_job,
  input  logic              pop,
  output btg_pkg::job_t     head,
  output btg_pkg::qstat_t   qstat
);

  btg_pkg::job_t mem [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign head        = mem[rd_ptr];
  assign qstat.full  = count == 2'd2;
  assign qstat.empty = count == 2'd0;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      if (push && !pop)      count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_job;
  end

endmodule

>>> hdl/btg_back.sv
// ----------------------------------------------------------------------------
// btg_back - waveform and envelope engine
// Sine ROM lookup, peak scaling, ramp scaling by serial division, output stage.
// ----------------------------------------------------------------------------
module btg_back (
  input  logic               clk,
  input  logic               rst,
  input  btg_pkg::cfg_t      cfg,
  input  btg_pkg::qstat_t    qstat,
  input  btg_pkg::job_t      head,
  output logic               pop,
  output logic               smp_valid,
  input  logic               smp_stall,
  output logic signed [14:0] sample,
  output logic               accent,
  output logic               last
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_TAB   = 3'd1;
  localparam logic [2:0] ST_SCALE = 3'd2;
  localparam logic [2:0] ST_ATT   = 3'd3;
  localparam logic [2:0] ST_REL   = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0]                   state;
  logic                         stage;
  logic [3:0]                   cnt;

  logic                         active;
  logic                         acc;
  logic                         lst;
  logic                         neg;
  logic [15:0]                  idx;
  logic [14:0]                  tab_q;
  logic [28:0]                  prod;
  logic [13:0]                  mag;
  logic [14:0]                  rem;
  logic [13:0]                  dvd;

  logic [btg_pkg::SINE_TABLE_BITS-1:0] tab_idx;
  logic [btg_pkg::TAB_AW-1:0]          tab_addr;
  logic                         sq_pos;
  logic                         head_neg;
  logic [15:0]                  tail;
  logic [15:0]                  ramp16;
  logic                         att_on;
  logic                         rel_on;
  logic [15:0]                  mul_b;
  logic [29:0]                  ramp_prod;
  logic [15:0]                  rem2;
  logic                         ge;
  logic [15:0]                  diff;
  logic [15:0]                  sc_r;
  logic [13:0]                  sc_q;
  logic [14:0]                  mag15;
  logic                         out_free;

  assign pop      = (state == ST_IDLE) && !qstat.empty;
  assign out_free = !smp_valid || !smp_stall;

  // quadrant decode of the queued phase
  always_comb begin
    tab_idx  = head.phase[29 -: btg_pkg::SINE_TABLE_BITS];
    tab_addr = head.phase[30] ? (btg_pkg::QSIZE_A - {1'b0, tab_idx}) : {1'b0, tab_idx};
    sq_pos   = (head.phase != 32'd0) && !head.phase[31];
    head_neg = head.accent ? !sq_pos : head.phase[31];
  end

  // divide by 32767: quotient from the top bits, one correction step
  always_comb begin
    sc_q = prod[28:15];
    sc_r = {1'b0, prod[14:0]} + {2'b00, sc_q};
    if (sc_r >= 16'd32767) sc_q = sc_q + 14'd1;
  end

  // ramp conditions and the shared ramp multiplier
  always_comb begin
    ramp16    = {1'b0, cfg.ramp_length};
    tail      = btg_pkg::LAST_INDEX - idx;
    att_on    = active && (ramp16 != 16'd0) && (idx < ramp16);
    rel_on    = active && (ramp16 != 16'd0) && (tail < ramp16);
    mul_b     = (state == ST_ATT) ? idx : tail;
    ramp_prod = 30'(mag) * 30'(mul_b);
  end

  // one restoring division step
  always_comb begin
    rem2 = {rem, dvd[13]};
    ge   = rem2 >= ramp16;
    diff = rem2 - ramp16;
  end

  assign mag15 = {1'b0, mag};

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      stage     <= 1'b0;
      cnt       <= 4'd0;
      smp_valid <= 1'b0;
    end else begin
      // output valid: set on a new sample, cleared once taken
      if ((state == ST_OUT) && out_free) smp_valid <= 1'b1;
      else if (smp_valid && !smp_stall)  smp_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (pop) state <= ST_TAB;
        end
        ST_TAB: begin
          state <= ST_SCALE;
        end
        ST_SCALE: begin
          state <= ST_ATT;
        end
        ST_ATT: begin
          if (att_on) begin
            stage <= 1'b0;
            cnt   <= 4'd13;
            state <= ST_DIV;
          end else begin
            state <= ST_REL;
          end
        end
        ST_REL: begin
          if (rel_on) begin
            stage <= 1'b1;
            cnt   <= 4'd13;
            state <= ST_DIV;
          end else begin
            state <= ST_OUT;
          end
        end
        ST_DIV: begin
          cnt <= cnt - 4'd1;
          if (cnt == 4'd0) state <= stage ? ST_OUT : ST_REL;
        end
        ST_OUT: begin
          if (out_free) state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (pop) begin
          active <= head.active;
          acc    <= head.accent;
          lst    <= head.last;
          neg    <= head_neg;
          idx    <= head.idx;
          tab_q  <= btg_pkg::SIN_TAB[tab_addr];
        end
      end
      ST_TAB: begin
        prod <= 29'(cfg.sine_peak) * 29'(tab_q);
      end
      ST_SCALE: begin
        if (!active)  mag <= 14'd0;
        else if (acc) mag <= cfg.square_peak;
        else          mag <= sc_q;
      end
      ST_ATT, ST_REL: begin
        rem <= ramp_prod[28:14];
        dvd <= ramp_prod[13:0];
      end
      ST_DIV: begin
        rem <= ge ? diff[14:0] : rem2[14:0];
        dvd <= {dvd[12:0], ge};
        if (cnt == 4'd0) mag <= {dvd[12:0], ge};
      end
      ST_OUT: begin
        if (out_free) begin
          sample <= neg ? $signed(~mag15 + 15'd1) : $signed(mag15);
          accent <= acc;
          last   <= lst;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> hdl/beat_tone_generator_with_ramp_top.sv
// ----------------------------------------------------------------------------
// beat_tone_generator_with_ramp_top - metronome tone generator
// One enveloped sample per tick; accent square or sine beat with linear ramps.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+--------------------------------------
//  tick    | tick_valid/tick_stall | start_req, note_step
//  smp     | smp_valid/smp_stall   | sample, accent, last
//  cfg     | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
//  Each request steps through the back engine's table, scale, attack, release
//  and output states, plus a serial divide by ramp_length for each ramp that
//  applies. The front queues up to two requests ahead of the engine.
//  Synchronous active-high reset clears beat state, queue and output valid.
//  A stalled output holds the engine in its output state; the queue then
//  fills and tick_stall rises. cfg_ready is always high.
// ----------------------------------------------------------------------------
module beat_tone_generator_with_ramp_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               tick_valid,
  output logic               tick_stall,
  input  logic               start_req,
  input  logic [31:0]        note_step,
  output logic               smp_valid,
  input  logic               smp_stall,
  output logic signed [14:0] sample,
  output logic               accent,
  output logic               last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  btg_pkg::cfg_t   cfg;
  btg_pkg::job_t   wr_job;
  btg_pkg::job_t   head;
  btg_pkg::qstat_t qstat;
  logic            q_push;
  logic            q_pop;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ramp_length       <= btg_pkg::RST_RAMP_LENGTH;
      cfg.sine_peak         <= btg_pkg::RST_SINE_PEAK;
      cfg.square_peak       <= btg_pkg::RST_SQUARE_PEAK;
      cfg.beats_per_measure <= btg_pkg::RST_BEATS_PER_MEASURE;
      cfg.root_step         <= btg_pkg::RST_ROOT_STEP;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        btg_pkg::REG_RAMP_LENGTH:       cfg.ramp_length       <= cfg_data[14:0];
        btg_pkg::REG_SINE_PEAK:         cfg.sine_peak         <= cfg_data[13:0];
        btg_pkg::REG_SQUARE_PEAK:       cfg.square_peak       <= cfg_data[13:0];
        btg_pkg::REG_BEATS_PER_MEASURE: cfg.beats_per_measure <= cfg_data[6:0];
        btg_pkg::REG_ROOT_STEP:         cfg.root_step         <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  btg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .tick_valid (tick_valid),
    .tick_stall (tick_stall),
    .start_req  (start_req),
    .note_step  (note_step),
    .qstat      (qstat),
    .push       (q_push),
    .job        (wr_job)
  );

  btg_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_job (wr_job),
    .pop    (q_pop),
    .head   (head),
    .qstat  (qstat)
  );

  btg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .qstat     (qstat),
    .head      (head),
    .pop       (q_pop),
    .smp_valid (smp_valid),
    .smp_stall (smp_stall),
    .sample    (sample),
    .accent    (accent),
    .last      (last)
  );

  // queue is never written when full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !qstat.full)
    else $error("job queue written while full");

  // engine never takes a job from an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !qstat.empty)
    else $error("job queue read while empty");

  // a job pushed without a pop is visible next cycle
  a_push_seen: assert property (@(posedge clk) disable iff (rst)
    (q_push && !q_pop) |=> !qstat.empty)
    else $error("pushed job lost");

endmodule

>>> tb/beat_tone_generator_with_ramp_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// beat_tone_generator_with_ramp_top_tb - self-checking bench for the tone block
// Ticks are fed from a queue through a clocked driver and every tick is scored
// against a bit-true predictor of the beat, accent, sine ROM and ramp
// envelope. A clocked monitor compares each sample in order. Runs a directed
// set, then random ticks under several register settings and idle/stall mixes.
// ----------------------------------------------------------------------------
module beat_tone_generator_with_ramp_top_tb;

  // pi/2 in Q30 for the sine ROM
  localparam longint QUARTER_TURN_Q30 = 64'sd1686629713;
  localparam int     WATCHDOG_LIMIT   = 4000;
  localparam int     TAIL_CYCLES      = 50;

  typedef struct packed {
    logic        start;
    logic [31:0] step;
  } tick_t;

  typedef struct packed {
    logic signed [14:0] smp;
    logic               acc;
    logic               lst;
  } tone_t;

  logic               clk        = 1'b0;
  logic               rst        = 1'b1;
  logic               tick_valid = 1'b0;
  logic               tick_stall;
  logic               start_req  = 1'b0;
  logic [31:0]        note_step  = '0;
  logic               smp_valid;
  logic               smp_stall  = 1'b0;
  logic signed [14:0] sample;
  logic               accent;
  logic               last;
  logic               cfg_valid  = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index  = btg_pkg::REG_RAMP_LENGTH;
  logic [31:0]        cfg_data   = '0;

  // tick requests waiting to go, samples waiting to come back
  tick_t tick_req_q[$];
  tone_t tone_expect_q[$];

  int err_count = 0;
  int gap_pct   = 0;
  int stall_pct = 0;
  int wd_count  = 0;

  // predictor registers and beat state
  logic [14:0] cfg_ramp;
  logic [13:0] cfg_sine_pk;
  logic [13:0] cfg_square_pk;
  logic [6:0]  cfg_bpm;
  logic [31:0] cfg_root;
  logic [31:0] ph_acc;
  logic [15:0] smp_idx;
  logic [6:0]  beat_cnt;
  logic        playing;
  logic        accent_on;
  logic [31:0] beat_step;
  longint      tone_rom [0:btg_pkg::QSIZE];

  beat_tone_generator_with_ramp_top u_top (
    .clk       (clk),
    .rst       (rst),
    .tick_valid(tick_valid),
    .tick_stall(tick_stall),
    .start_req (start_req),
    .note_step (note_step),
    .smp_valid (smp_valid),
    .smp_stall (smp_stall),
    .sample    (sample),
    .accent    (accent),
    .last      (last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // quarter-wave Q15 sine, Q30 series to x^8, each term the last times x, rounded half up
  function automatic void tone_rom_fill();
    longint x;
    longint term;
    longint acc;
    longint v;
    int     k;
    int     n;
    for (k = 0; k <= btg_pkg::QSIZE; k++) begin
      x    = (QUARTER_TURN_Q30 * longint'(k)) / longint'(btg_pkg::QSIZE);
      term = x;
      acc  = x;
      for (n = 1; n <= 7; n++) begin
        term = (term * x) / 64'sd1073741824;
        term = -(term / longint'((2 * n) * (2 * n + 1)));
        acc  = acc + term;
      end
      if (acc < 0) acc = 0;
      v = (acc + 64'sd16384) / 64'sd32768;
      if (v > 64'sd32767) v = 64'sd32767;
      tone_rom[k] = v;
    end
  endfunction

  function automatic void tone_reset();
    cfg_ramp      = 15'd24000;
    cfg_sine_pk   = 14'd2512;
    cfg_square_pk = 14'd316;
    cfg_bpm       = 7'd8;
    cfg_root      = 32'd11698770;
    ph_acc        = '0;
    smp_idx       = '0;
    beat_cnt      = 7'd1;
    playing       = 1'b0;
    accent_on     = 1'b0;
    beat_step     = '0;
  endfunction

  // quadrant from the top two phase bits, mirrored and negated as needed
  function automatic longint sine_at(input logic [31:0] ph);
    int     idx;
    longint v;
    idx = int'(ph >> (30 - btg_pkg::SINE_TABLE_BITS)) & (btg_pkg::QSIZE - 1);
    v   = ph[30] ? tone_rom[btg_pkg::QSIZE - idx] : tone_rom[idx];
    return ph[31] ? -v : v;
  endfunction

  // one tick in, one sample out; advances the beat state
  function automatic tone_t tone_predict(input logic start, input logic [31:0] step);
    tone_t       res;
    logic [6:0]  bpm_eff;
    longint      s;
    longint      i;
    longint      tail;
    longint      r;
    res = '0;
    s   = 0;
    if (start) begin
      bpm_eff = (cfg_bpm == 7'd0) ? 7'd1 : cfg_bpm;
      if (beat_cnt >= bpm_eff) begin
        accent_on = 1'b1;
        beat_cnt  = 7'd1;
      end else begin
        accent_on = 1'b0;
        beat_cnt  = beat_cnt + 7'd1;
      end
      beat_step = accent_on ? cfg_root : step;
      ph_acc    = '0;
      smp_idx   = '0;
      playing   = 1'b1;
    end
    if (playing) begin
      i    = longint'(smp_idx);
      tail = longint'(btg_pkg::SAMPLES_PER_NOTE - 1) - i;
      r    = longint'(cfg_ramp);
      if (accent_on) begin
        if (ph_acc != 32'd0 && ph_acc < 32'h8000_0000) s = longint'(cfg_square_pk);
        else s = -longint'(cfg_square_pk);
      end else begin
        s = (longint'(cfg_sine_pk) * sine_at(ph_acc)) / 32767;
      end
      // attack then release, each truncating toward zero
      if (r > 0 && i < r) s = (s * i) / r;
      if (r > 0 && tail < r) s = (s * tail) / r;
      res.acc = accent_on;
      if (smp_idx >= 16'(btg_pkg::SAMPLES_PER_NOTE - 1)) begin
        res.lst = 1'b1;
        playing = 1'b0;
      end
      smp_idx = smp_idx + 16'd1;
      ph_acc  = ph_acc + beat_step;
    end
    res.smp = s[14:0];
    return res;
  endfunction

  task automatic note_error(input string what, input longint got, input longint want);
    $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    err_count++;
  endtask

  // tick driver: payload held while stalled
  always @(posedge clk) begin : tick_drv
    tick_t nxt;
    if (rst) begin
      tick_valid <= 1'b0;
    end else begin
      if (tick_valid && !tick_stall)
        tone_expect_q.insert(tone_expect_q.size(), tone_predict(start_req, note_step));
      if (!(tick_valid && tick_stall)) begin
        if (tick_req_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
          nxt = tick_req_q.pop_front();
          tick_valid <= 1'b1;
          start_req  <= nxt.start;
          note_step  <= nxt.step;
        end else begin
          tick_valid <= 1'b0;
        end
      end
    end
  end

  // sample monitor, oldest expectation first
  always @(posedge clk) begin : smp_mon
    tone_t want;
    if (rst) begin
      smp_stall <= 1'b0;
    end else begin
      if (smp_valid && !smp_stall) begin
        if (tone_expect_q.size() == 0) begin
          note_error("sample with no request", longint'(sample), 0);
        end else begin
          want = tone_expect_q.pop_front();
          if (sample !== want.smp)
            note_error("sample", longint'(sample), longint'(want.smp));
          if (accent !== want.acc)
            note_error("accent", longint'(accent), longint'(want.acc));
          if (last !== want.lst)
            note_error("last", longint'(last), longint'(want.lst));
        end
      end
      smp_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // stop if nothing moves on any channel for too long
  always @(posedge clk) begin
    if ((tick_valid && !tick_stall) || (smp_valid && !smp_stall) || (cfg_valid && cfg_ready))
      wd_count <= 0;
    else
      wd_count <= wd_count + 1;
    if (wd_count >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress", $time);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic push_tick(input logic start, input logic [31:0] step);
    tick_t t;
    t.start = start;
    t.step  = step;
    tick_req_q.insert(tick_req_q.size(), t);
  endtask

  // everything sent and every sample back
  task automatic wait_idle();
    do @(negedge clk);
    while (tick_req_q.size() != 0 || tick_valid || tone_expect_q.size() != 0);
  endtask

  // called at a rising edge; returns at the edge that takes the write
  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    case (idx)
      btg_pkg::REG_RAMP_LENGTH:       cfg_ramp      = data[14:0];
      btg_pkg::REG_SINE_PEAK:         cfg_sine_pk   = data[13:0];
      btg_pkg::REG_SQUARE_PEAK:       cfg_square_pk = data[13:0];
      btg_pkg::REG_BEATS_PER_MEASURE: cfg_bpm       = data[6:0];
      btg_pkg::REG_ROOT_STEP:         cfg_root      = data;
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [14:0] ramp, input logic [13:0] sine_pk,
                          input logic [13:0] square_pk, input logic [6:0] bpm,
                          input logic [31:0] root);
    @(posedge clk);
    cfg_write(btg_pkg::REG_RAMP_LENGTH, 32'(ramp));
    cfg_write(btg_pkg::REG_SINE_PEAK, 32'(sine_pk));
    cfg_write(btg_pkg::REG_SQUARE_PEAK, 32'(square_pk));
    cfg_write(btg_pkg::REG_BEATS_PER_MEASURE, 32'(bpm));
    cfg_write(btg_pkg::REG_ROOT_STEP, root);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [13:0] pick_peak();
    case ($urandom_range(3))
      0:       return 14'd10000;
      1:       return 14'd16383;
      2:       return 14'd0;
      default: return 14'($urandom_range(10000));
    endcase
  endfunction

  // stimulus
  initial begin : stim
    logic [14:0] ramp;
    logic [6:0]  bpm;
    logic [31:0] root;
    int          mode;
    int          rep;
    int          n;
    tone_rom_fill();
    tone_reset();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset settings: idle ticks first, then a short beat
    push_tick(1'b0, 32'hFFFF_FFFF);
    push_tick(1'b0, 32'h0000_0000);
    push_tick(1'b1, 32'h0800_0000);
    repeat (3) push_tick(1'b0, $urandom());
    wait_idle();

    // unscaled quarter steps hit each quadrant; second beat is the accent
    set_regs(15'd0, 14'd10000, 14'd10000, 7'd3, 32'h4000_0000);
    push_tick(1'b1, 32'h4000_0000);
    repeat (4) push_tick(1'b0, 32'h0);
    push_tick(1'b1, 32'hFFFF_FFFF);
    push_tick(1'b0, 32'h0);
    push_tick(1'b1, 32'h1234_5678);
    repeat (4) push_tick(1'b0, 32'hFFFF_FFFF);
    wait_idle();

    // largest peaks, every beat an accent, short attack ramp
    set_regs(15'd4, 14'd16383, 14'd16383, 7'd1, 32'hFFFF_FFFF);
    push_tick(1'b1, 32'h0);
    repeat (5) push_tick(1'b0, 32'h0);
    wait_idle();

    // zero beats per measure acts as one
    set_regs(15'd1, 14'd0, 14'd1, 7'd0, 32'h0);
    push_tick(1'b1, 32'h8000_0000);
    push_tick(1'b0, 32'h0);
    wait_idle();

    // random ticks: idle mixes none, sender, receiver, both
    for (mode = 0; mode < 4; mode++) begin
      for (rep = 0; rep < 2; rep++) begin
        wait_idle();
        case ($urandom_range(3))
          0:       ramp = 15'd0;
          1:       ramp = 15'($urandom_range(1, 16));
          2:       ramp = 15'($urandom_range(24000));
          default: ramp = 15'd24000;
        endcase
        case ($urandom_range(4))
          0:       bpm = 7'd1;
          1:       bpm = 7'($urandom_range(2, 8));
          2:       bpm = 7'd64;
          3:       bpm = 7'd0;
          default: bpm = 7'd127;
        endcase
        case ($urandom_range(2))
          0:       root = $urandom();
          1:       root = 32'h0;
          default: root = 32'hFFFF_FFFF;
        endcase
        set_regs(ramp, pick_peak(), pick_peak(), bpm, root);
        @(negedge clk);
        gap_pct   = (mode == 1) ? 87 : (mode == 3) ? 25 : 0;
        stall_pct = (mode == 2) ? 87 : (mode == 3) ? 25 : 0;
        for (n = 0; n < 78; n++)
          push_tick((n == 0) || ($urandom_range(7) == 0), $urandom());
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tone_expect_q.size() != 0)
      note_error("samples never returned", 0, longint'(tone_expect_q.size()));
    if (err_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
